// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/mrfo_pkg.sv -----
// ----------------------------------------------------------------------------
// mrfo_pkg
// Codes, field widths and shared types of the multi-ring FIFO.
// ----------------------------------------------------------------------------
package mrfo_pkg;

  localparam int FUNC_W     = 2;
  localparam int RING_F_W   = 2;
  localparam int DATA_F_W   = 32;
  localparam int STATUS_W   = 2;
  localparam int FILL_W     = 5;
  localparam int MASK_W     = 4;
  localparam int CAP_F_W    = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;
  localparam int MAX_RINGS  = 8;
  localparam int CAP_RESET  = 16;

  // Operation codes.
  localparam logic [FUNC_W-1:0] FN_WRITE = 2'd0;
  localparam logic [FUNC_W-1:0] FN_READ  = 2'd1;
  localparam logic [FUNC_W-1:0] FN_CLEAR = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_DISABLED = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OVERWRITE = 2'd2;

  // Decision for one operation, from the ring controller to the datapath.
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [FILL_W-1:0]   fill;
    logic                rd_ok;
    logic                wr_en;
    logic                rd_en;
  } op_dec_t;

endpackage

// ----- rtl/mrfo_if.sv -----
// ----------------------------------------------------------------------------
// mrfo_if
// Valid/ready channels of the multi-ring FIFO: operations, results, config.
// ----------------------------------------------------------------------------
interface mrfo_op_if import mrfo_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  logic [RING_F_W-1:0] ring;
  logic [DATA_F_W-1:0] wr_data;

  modport source (output valid, func, ring, wr_data, input ready);
  modport sink (input valid, func, ring, wr_data, output ready);
endinterface

interface mrfo_res_if import mrfo_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [DATA_F_W-1:0] rd_data;
  logic [FILL_W-1:0]   fill_count;

  modport source (output valid, status, rd_data, fill_count, input ready);
  modport sink (input valid, status, rd_data, fill_count, output ready);
endinterface

interface mrfo_cfg_if import mrfo_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/multi_ring_fifo_overwrite.sv -----
// An operation passes the decision stage, then the result register; the
// entry store read is registered. Throughput: one operation per cycle unless
// results stall. Pointers and counts update at a transfer without cfg.valid.
// Reset (rst, synchronous) clears pointers, counts and the configuration
// registers at once; the entry store is not cleared and there is no
// clearing pass, so operations are taken from the first cycle after reset.
// ----------------------------------------------------------------------------
// multi_ring_fifo_overwrite
// Several circular FIFOs in one shared entry store, with optional overwrite.
// ----------------------------------------------------------------------------
module multi_ring_fifo_overwrite import mrfo_pkg::*; #(
  parameter int NUM_RINGS  = 4,
  parameter int DEPTH      = 16,
  parameter int ITEM_WIDTH = 32
) (
  input  logic       clk,
  input  logic       rst,
  mrfo_op_if.sink    op,
  mrfo_res_if.source res,
  mrfo_cfg_if.sink   cfg
);

  localparam int ADDR_W = $clog2(NUM_RINGS * DEPTH);

  op_dec_t             dec;
  logic [ADDR_W-1:0]   wr_addr;
  logic [ADDR_W-1:0]   rd_addr;
  logic                accept;
  logic [ITEM_WIDTH-1:0] ram_q;

  // Decision stage, aligned with the store's registered read data.
  logic                s1_valid;
  logic [STATUS_W-1:0] s1_status;
  logic [FILL_W-1:0]   s1_fill;
  logic                s1_rd_ok;
  logic                s1_move;

  // Result register.
  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [DATA_F_W-1:0] out_rd_data;
  logic [FILL_W-1:0]   out_fill;

  assign s1_move  = s1_valid && (!out_valid || res.ready);
  assign op.ready = !s1_valid || s1_move;
  assign accept   = op.valid && op.ready;

  mrfo_ctrl #(
    .NUM_RINGS (NUM_RINGS),
    .DEPTH     (DEPTH)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .accept  (accept),
    .func    (op.func),
    .ring    (op.ring),
    .dec     (dec),
    .wr_addr (wr_addr),
    .rd_addr (rd_addr)
  );

  // The read enable is only raised on a transfer, so the read data holds
  // while the decision stage is stalled.
  mrfo_ram #(
    .WIDTH (ITEM_WIDTH),
    .DEPTH (NUM_RINGS * DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (accept && dec.wr_en),
    .waddr (wr_addr),
    .wdata (ITEM_WIDTH'(op.wr_data)),
    .re    (accept && dec.rd_en),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_status <= dec.status;
      s1_fill   <= dec.fill;
      s1_rd_ok  <= dec.rd_ok;
    end
    if (s1_move) begin
      out_status  <= s1_status;
      out_fill    <= s1_fill;
      out_rd_data <= s1_rd_ok ? DATA_F_W'(ram_q) : '0;
    end
  end

  assign res.valid      = out_valid;
  assign res.status     = out_status;
  assign res.rd_data    = out_rd_data;
  assign res.fill_count = out_fill;

endmodule

// ----- rtl/mrfo_ram.sv -----
// ----------------------------------------------------------------------------
// mrfo_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module mrfo_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/mrfo_ctrl.sv -----
// ----------------------------------------------------------------------------
// mrfo_ctrl
// Ring pointers, fill counts and configuration registers; decides each
// operation and forms the entry store addresses.
// ----------------------------------------------------------------------------
module mrfo_ctrl import mrfo_pkg::*; #(
  parameter int NUM_RINGS = 4,
  parameter int DEPTH     = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  mrfo_cfg_if.sink                             cfg,
  input  logic                                 accept,
  input  logic [FUNC_W-1:0]                    func,
  input  logic [RING_F_W-1:0]                  ring,
  output op_dec_t                              dec,
  output logic [$clog2(NUM_RINGS*DEPTH)-1:0]   wr_addr,
  output logic [$clog2(NUM_RINGS*DEPTH)-1:0]   rd_addr
);

  localparam int PTR_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int RING_W  = (NUM_RINGS > 1) ? $clog2(NUM_RINGS) : 1;
  localparam int ADDR_W  = $clog2(NUM_RINGS * DEPTH);
  localparam int CAP_RST = (CAP_RESET > DEPTH) ? DEPTH : CAP_RESET;

  logic [PTR_W-1:0]  rd_ptr [NUM_RINGS];
  logic [PTR_W-1:0]  wr_ptr [NUM_RINGS];
  logic [CNT_W-1:0]  count  [NUM_RINGS];
  logic [MASK_W-1:0] enable_mask;
  logic [CNT_W-1:0]  cap_eff;
  logic              overwrite;

  logic [RING_W-1:0]    ridx;
  logic                 ring_on;
  logic [PTR_W-1:0]     cur_rp;
  logic [PTR_W-1:0]     cur_wp;
  logic [CNT_W-1:0]     cur_cnt;
  logic [CNT_W-1:0]     rp_inc;
  logic [CNT_W-1:0]     wp_inc;
  logic [PTR_W-1:0]     rp_adv;
  logic [PTR_W-1:0]     wp_adv;
  logic [PTR_W-1:0]     rd_ptr_next;
  logic [PTR_W-1:0]     wr_ptr_next;
  logic [CNT_W-1:0]     count_next;
  logic                 upd;
  logic [CAP_F_W-1:0]   cap_in;
  logic [CNT_W-1:0]     cap_wr;
  logic [MASK_W-1:0]    rise;
  logic [MAX_RINGS-1:0] rise_ext;

  assign cfg.ready = 1'b1;

  // Effective capacity of a capacity write: zero acts as one, clamped to the depth.
  always_comb begin
    cap_in = cfg.data[CAP_F_W-1:0];
    if (cap_in == '0) begin
      cap_wr = CNT_W'(1);
    end else if (int'(cap_in) > DEPTH) begin
      cap_wr = CNT_W'(DEPTH);
    end else begin
      cap_wr = CNT_W'(cap_in);
    end
    rise     = cfg.data[MASK_W-1:0] & ~enable_mask;
    rise_ext = MAX_RINGS'(rise);
  end

  always_comb begin
    ridx    = RING_W'(ring);
    ring_on = (int'(ring) < NUM_RINGS) && enable_mask[ring];
    cur_rp  = rd_ptr[ridx];
    cur_wp  = wr_ptr[ridx];
    cur_cnt = count[ridx];
    rp_inc  = CNT_W'(cur_rp) + CNT_W'(1);
    wp_inc  = CNT_W'(cur_wp) + CNT_W'(1);
    rp_adv  = (rp_inc >= cap_eff) ? '0 : rp_inc[PTR_W-1:0];
    wp_adv  = (wp_inc >= cap_eff) ? '0 : wp_inc[PTR_W-1:0];

    dec         = '0;
    rd_ptr_next = cur_rp;
    wr_ptr_next = cur_wp;
    count_next  = cur_cnt;
    upd         = 1'b0;

    if (!ring_on) begin
      dec.status = ST_DISABLED;
    end else begin
      dec.status = ST_OK;
      case (func)
        FN_WRITE: begin
          if (cur_cnt < cap_eff) begin
            dec.wr_en   = 1'b1;
            wr_ptr_next = wp_adv;
            count_next  = cur_cnt + CNT_W'(1);
            upd         = 1'b1;
          end else begin
            dec.status = ST_FULL;
            // Overwrite drops the oldest entry, so the read pointer follows
            // the write pointer and the count stays at capacity.
            if (overwrite) begin
              dec.wr_en   = 1'b1;
              wr_ptr_next = wp_adv;
              rd_ptr_next = wp_adv;
              upd         = 1'b1;
            end
          end
        end
        FN_READ: begin
          if (cur_cnt == '0) begin
            dec.status = ST_EMPTY;
          end else begin
            dec.rd_en   = 1'b1;
            dec.rd_ok   = 1'b1;
            rd_ptr_next = rp_adv;
            count_next  = cur_cnt - CNT_W'(1);
            upd         = 1'b1;
          end
        end
        FN_CLEAR: begin
          rd_ptr_next = '0;
          wr_ptr_next = '0;
          count_next  = '0;
          upd         = 1'b1;
        end
        default: begin
        end
      endcase
      dec.fill = FILL_W'(count_next);
    end

    wr_addr = ADDR_W'(ridx) * ADDR_W'(DEPTH) + ADDR_W'(cur_wp);
    rd_addr = ADDR_W'(ridx) * ADDR_W'(DEPTH) + ADDR_W'(cur_rp);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enable_mask <= '0;
      cap_eff     <= CNT_W'(CAP_RST);
      overwrite   <= 1'b0;
      for (int r = 0; r < NUM_RINGS; r++) begin
        rd_ptr[r] <= '0;
        wr_ptr[r] <= '0;
        count[r]  <= '0;
      end
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_ENABLE: begin
          // A ring that is switched on starts empty.
          for (int r = 0; r < NUM_RINGS; r++) begin
            if (rise_ext[r]) begin
              rd_ptr[r] <= '0;
              wr_ptr[r] <= '0;
              count[r]  <= '0;
            end
          end
          enable_mask <= cfg.data[MASK_W-1:0];
        end
        CFG_CAPACITY: begin
          cap_eff <= cap_wr;
          for (int r = 0; r < NUM_RINGS; r++) begin
            rd_ptr[r] <= '0;
            wr_ptr[r] <= '0;
            count[r]  <= '0;
          end
        end
        CFG_OVERWRITE: begin
          overwrite <= cfg.data[0];
        end
        default: begin
        end
      endcase
    end else if (accept && upd) begin
      rd_ptr[ridx] <= rd_ptr_next;
      wr_ptr[ridx] <= wr_ptr_next;
      count[ridx]  <= count_next;
    end
  end

endmodule

// ----- rtl/mrfo_checker.sv -----
// ----------------------------------------------------------------------------
// mrfo_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mrfo_checker import mrfo_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                res_valid,
  input logic                res_ready,
  input logic [STATUS_W-1:0] res_status,
  input logic [DATA_F_W-1:0] res_rd_data,
  input logic [FILL_W-1:0]   res_fill_count
);

  `ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid, "result dropped while stalled")

  `ASSERT_IMPLIES(a_disabled_zero, res_valid && (res_status == ST_DISABLED), (res_rd_data == '0) && (res_fill_count == '0), "disabled ring result not zero")

  `ASSERT_IMPLIES(a_empty_zero, res_valid && (res_status == ST_EMPTY), (res_rd_data == '0) && (res_fill_count == '0), "empty read result not zero")

  `ASSERT_IMPLIES(a_full_no_data, res_valid && (res_status == ST_FULL), (res_rd_data == '0) && (res_fill_count != '0), "full result carries data or no fill")

endmodule

bind multi_ring_fifo_overwrite mrfo_checker u_mrfo_checker (
  .clk            (clk),
  .rst            (rst),
  .res_valid      (res.valid),
  .res_ready      (res.ready),
  .res_status     (res.status),
  .res_rd_data    (res.rd_data),
  .res_fill_count (res.fill_count)
);
